[hw/rtl/cdcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcc_pkg: shared definitions for the calendar day count converter
// Request and result types, micro-operation and condition codes, and the
// calendar helper functions used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cdcc_pkg;

    // Calendar constants.
    localparam int unsigned EPOCH_YEAR = 2000;
    localparam int unsigned YEAR_SPAN_DEF = 180;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [3:0] MONTHS = 4'd12;
    localparam logic [8:0] DAYS_LEAP = 9'd366;
    localparam logic [8:0] DAYS_NORM = 9'd365;

    // Lengths of the months in a common year.
    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Request and result payloads.
    typedef struct packed {
        logic        action;
        logic [15:0] day_count_in;
        logic [11:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
    } t_req;

    typedef struct packed {
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [2:0]  weekday;
        logic [15:0] day_count_out;
        logic        range_error;
    } t_res;

    // Micro-operations executed by the datapath.
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_CLAMP = 4'd1;
    localparam logic [3:0] OP_YSUB  = 4'd2;
    localparam logic [3:0] OP_MSUB  = 4'd3;
    localparam logic [3:0] OP_SETUP = 4'd4;
    localparam logic [3:0] OP_YADD  = 4'd5;
    localparam logic [3:0] OP_MADD  = 4'd6;
    localparam logic [3:0] OP_DADD  = 4'd7;
    localparam logic [3:0] OP_EMIT  = 4'd8;

    // Branch conditions selected by the control word.
    localparam logic [3:0] C_ALWAYS = 4'd0;
    localparam logic [3:0] C_START  = 4'd1;
    localparam logic [3:0] C_ACTION = 4'd2;
    localparam logic [3:0] C_YWALK  = 4'd3;
    localparam logic [3:0] C_MWALK  = 4'd4;
    localparam logic [3:0] C_YBAD   = 4'd5;
    localparam logic [3:0] C_YSUM   = 4'd6;
    localparam logic [3:0] C_MSUM   = 4'd7;
    localparam logic [3:0] C_OFREE  = 4'd8;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        logic [3:0] op;
        logic       en;
    } t_uctl;

    // Status flags handed from the datapath to the sequencer.
    typedef struct packed {
        logic action;
        logic ywalk;
        logic mwalk;
        logic ybad;
        logic ysum;
        logic msum;
    } t_flags;

    // Leap year test on an offset from the epoch; valid below 500 years.
    function automatic logic is_leap(input logic [8:0] yoff);
        logic leap;
        leap = (yoff[1:0] == 2'd0) && (yoff != 9'd100) && (yoff != 9'd200)
            && (yoff != 9'd300);
        return leap;
    endfunction

    function automatic logic [8:0] year_len(input logic [8:0] yoff);
        return is_leap(yoff) ? DAYS_LEAP : DAYS_NORM;
    endfunction

    // Month length for a month in 1..12 of the year at the given offset.
    function automatic logic [4:0] month_len(input logic [8:0] yoff,
                                             input logic [3:0] mon);
        logic [3:0] idx;
        logic [4:0] len;
        idx = mon - 4'd1;
        len = (idx < MONTHS) ? MONTH_DAYS[idx] : MONTH_DAYS[0];
        if ((mon == 4'd2) && is_leap(yoff)) begin
            len = 5'd29;
        end
        return len;
    endfunction

    // Number of days in the year window, evaluated at elaboration.
    function automatic logic [16:0] window_days(input int unsigned span);
        logic [16:0] sum;
        sum = 17'd0;
        for (int unsigned i = 0; i < span; i++) begin
            sum = sum + 17'(year_len(9'(i)));
        end
        return sum;
    endfunction

    // Remainder by seven: octal digits sum to the same residue since 8 = 1 mod 7.
    function automatic logic [2:0] mod7(input logic [16:0] x);
        logic [17:0] xe;
        logic [5:0]  s1;
        logic [3:0]  s2;
        xe = {1'b0, x};
        s1 = 6'(xe[2:0]) + 6'(xe[5:3]) + 6'(xe[8:6]) + 6'(xe[11:9])
           + 6'(xe[14:12]) + 6'(xe[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

[hw/rtl/cdcc_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcc_seq: microcode sequencer
// Holds the step counter and the control store. Each control word selects a
// micro-operation, a branch condition and the next step on either outcome.
// ----------------------------------------------------------------------------
module cdcc_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_ofree,
    input  cdcc_pkg::t_flags i_flags,
    output cdcc_pkg::t_uctl  o_uctl,
    output logic             o_idle
);

    // Step addresses of the program.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_CLAMP    = 4'd2;
    localparam logic [3:0] S_YWALK    = 4'd3;
    localparam logic [3:0] S_MWALK    = 4'd4;
    localparam logic [3:0] S_SETUP    = 4'd5;
    localparam logic [3:0] S_YSUM     = 4'd6;
    localparam logic [3:0] S_MSUM     = 4'd7;
    localparam logic [3:0] S_DADD     = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] cond;
        logic       gate;
        logic [3:0] jt;
        logic [3:0] jf;
    } t_uword;

    // Control store: the operation runs unless gated, when only a true
    // condition lets it run.
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        unique case (pc)
            S_IDLE:     w = '{cdcc_pkg::OP_NOP,   cdcc_pkg::C_START,  1'b0, S_DISPATCH, S_IDLE};
            S_DISPATCH: w = '{cdcc_pkg::OP_NOP,   cdcc_pkg::C_ACTION, 1'b0, S_SETUP, S_CLAMP};
            S_CLAMP:    w = '{cdcc_pkg::OP_CLAMP, cdcc_pkg::C_ALWAYS, 1'b0, S_YWALK, S_YWALK};
            S_YWALK:    w = '{cdcc_pkg::OP_YSUB,  cdcc_pkg::C_YWALK,  1'b1, S_YWALK, S_MWALK};
            S_MWALK:    w = '{cdcc_pkg::OP_MSUB,  cdcc_pkg::C_MWALK,  1'b1, S_MWALK, S_EMIT};
            S_SETUP:    w = '{cdcc_pkg::OP_SETUP, cdcc_pkg::C_YBAD,   1'b0, S_EMIT, S_YSUM};
            S_YSUM:     w = '{cdcc_pkg::OP_YADD,  cdcc_pkg::C_YSUM,   1'b1, S_YSUM, S_MSUM};
            S_MSUM:     w = '{cdcc_pkg::OP_MADD,  cdcc_pkg::C_MSUM,   1'b1, S_MSUM, S_DADD};
            S_DADD:     w = '{cdcc_pkg::OP_DADD,  cdcc_pkg::C_ALWAYS, 1'b0, S_EMIT, S_EMIT};
            S_EMIT:     w = '{cdcc_pkg::OP_EMIT,  cdcc_pkg::C_OFREE,  1'b1, S_IDLE, S_EMIT};
            default:    w = '{cdcc_pkg::OP_NOP,   cdcc_pkg::C_ALWAYS, 1'b0, S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

    logic [3:0] r_pc;
    logic [3:0] n_pc;
    t_uword     w_word;
    logic       w_cond;

    // Fetch the control word of the current step.
    assign w_word = ucode(r_pc);

    // Condition multiplexer.
    always_comb begin
        unique case (w_word.cond)
            cdcc_pkg::C_ALWAYS: w_cond = 1'b1;
            cdcc_pkg::C_START:  w_cond = i_start;
            cdcc_pkg::C_ACTION: w_cond = i_flags.action;
            cdcc_pkg::C_YWALK:  w_cond = i_flags.ywalk;
            cdcc_pkg::C_MWALK:  w_cond = i_flags.mwalk;
            cdcc_pkg::C_YBAD:   w_cond = i_flags.ybad;
            cdcc_pkg::C_YSUM:   w_cond = i_flags.ysum;
            cdcc_pkg::C_MSUM:   w_cond = i_flags.msum;
            cdcc_pkg::C_OFREE:  w_cond = i_ofree;
            default:            w_cond = 1'b0;
        endcase
    end

    // Next step and operation enable.
    assign n_pc       = w_cond ? w_word.jt : w_word.jf;
    assign o_uctl.op  = w_word.op;
    assign o_uctl.en  = !w_word.gate || w_cond;
    assign o_idle     = (r_pc == S_IDLE);

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hw/rtl/cdcc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcc_dp: calendar datapath
// Request registers, a day accumulator, year and
// month counters, and the flags that steer the sequencer's loops.
// ----------------------------------------------------------------------------
module cdcc_dp #(
    parameter int unsigned YEAR_SPAN = cdcc_pkg::YEAR_SPAN_DEF
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  cdcc_pkg::t_req   i_req,
    input  cdcc_pkg::t_uctl  i_uctl,
    output cdcc_pkg::t_flags o_flags,
    output cdcc_pkg::t_res   o_res
);

    localparam int unsigned YW = $clog2(YEAR_SPAN + 1);
    localparam logic [16:0] WINDOW = cdcc_pkg::window_days(YEAR_SPAN);
    localparam logic [16:0] LAST_DAY = WINDOW - 17'd1;
    localparam logic [11:0] YFIRST = 12'(cdcc_pkg::EPOCH_YEAR);
    localparam logic [11:0] YLAST = 12'(cdcc_pkg::EPOCH_YEAR + YEAR_SPAN - 1);

    // Latched request.
    logic          r_act;
    logic [15:0]   r_cin;
    logic [11:0]   r_yin;
    logic [3:0]    r_min;
    logic [4:0]    r_din;

    // Working registers.
    logic [16:0]   r_acc;
    logic [YW-1:0] r_yoff;
    logic [3:0]    r_mon;
    logic [15:0]   r_count;
    logic          r_err;

    logic [11:0]   w_ytgt;
    logic [8:0]    w_ylen;
    logic [8:0]    w_moff;
    logic [4:0]    w_mlen;
    logic [16:0]   w_csum;
    logic [16:0]   w_cdec;

    // Year and month lengths at the current walk position.
    assign w_ytgt = r_yin - YFIRST;
    assign w_ylen = cdcc_pkg::year_len(9'(r_yoff));
    assign w_moff = r_act ? w_ytgt[8:0] : 9'(r_yoff);
    assign w_mlen = cdcc_pkg::month_len(w_moff, r_mon);

    // Final day addition for a date request.
    assign w_csum = r_acc + 17'(r_din);
    assign w_cdec = (w_csum == 17'd0) ? w_csum : w_csum - 17'd1;

    // Loop flags.
    assign o_flags.action = r_act;
    assign o_flags.ywalk  = (r_acc >= 17'(w_ylen));
    assign o_flags.mwalk  = (r_mon < cdcc_pkg::MONTHS) && (r_acc >= 17'(w_mlen));
    assign o_flags.ybad   = (r_yin < YFIRST) || (r_yin > YLAST);
    assign o_flags.ysum   = (12'(r_yoff) < w_ytgt);
    assign o_flags.msum   = (r_mon < r_min);

    // Result fields; a date request reports no calendar date.
    always_comb begin
        o_res.year_out      = r_act ? 12'd0 : YFIRST + 12'(r_yoff);
        o_res.month_out     = r_act ? 4'd0 : r_mon;
        o_res.day_out       = r_act ? 5'd0 : r_acc[4:0] + 5'd1;
        o_res.weekday       = cdcc_pkg::mod7({1'b0, r_count} + 17'd6);
        o_res.day_count_out = r_count;
        o_res.range_error   = r_err;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_act <= i_req.action;
            r_cin <= i_req.day_count_in;
            r_yin <= i_req.year_in;
            r_min <= i_req.month_in;
            r_din <= i_req.day_in;
        end else if (i_uctl.op == cdcc_pkg::OP_SETUP) begin
            // Out-of-range months are folded into 1..12.
            if (r_min == 4'd0) begin
                r_min <= 4'd1;
            end else if (r_min > cdcc_pkg::MONTHS) begin
                r_min <= cdcc_pkg::MONTHS;
            end
        end
    end

    // Micro-operation execution.
    always_ff @(posedge i_clk) begin
        if (i_uctl.en) begin
            case (i_uctl.op)
                cdcc_pkg::OP_CLAMP: begin
                    if ({1'b0, r_cin} > LAST_DAY) begin
                        r_acc   <= LAST_DAY;
                        r_count <= LAST_DAY[15:0];
                        r_err   <= 1'b1;
                    end else begin
                        r_acc   <= {1'b0, r_cin};
                        r_count <= r_cin;
                        r_err   <= 1'b0;
                    end
                    r_yoff <= '0;
                    r_mon  <= 4'd1;
                end
                cdcc_pkg::OP_YSUB: begin
                    r_acc  <= r_acc - 17'(w_ylen);
                    r_yoff <= r_yoff + YW'(1);
                end
                cdcc_pkg::OP_MSUB: begin
                    r_acc <= r_acc - 17'(w_mlen);
                    r_mon <= r_mon + 4'd1;
                end
                cdcc_pkg::OP_SETUP: begin
                    r_acc  <= 17'd0;
                    r_yoff <= '0;
                    r_mon  <= 4'd1;
                    r_err  <= (r_min == 4'd0) || (r_min > cdcc_pkg::MONTHS)
                           || o_flags.ybad;
                    r_count <= (r_yin > YLAST) ? cdcc_pkg::COUNT_MAX : 16'd0;
                end
                cdcc_pkg::OP_YADD: begin
                    r_acc  <= r_acc + 17'(w_ylen);
                    r_yoff <= r_yoff + YW'(1);
                end
                cdcc_pkg::OP_MADD: begin
                    r_acc <= r_acc + 17'(w_mlen);
                    r_mon <= r_mon + 4'd1;
                end
                cdcc_pkg::OP_DADD: begin
                    // Day zero of the epoch month underflows; large counts saturate.
                    if (w_cdec > {1'b0, cdcc_pkg::COUNT_MAX}) begin
                        r_count <= cdcc_pkg::COUNT_MAX;
                        r_err   <= 1'b1;
                    end else begin
                        r_count <= w_cdec[15:0];
                        r_err   <= r_err || (w_csum == 17'd0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/calendar_day_count_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_count_converter_top: Gregorian date and day count converter
// Converts a day count from 2000-01-01 into a date and weekday, or a date
// into a day count, under control of a small microcode sequencer.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on i_valid/o_ready with payload i_req; the result leaves
// on o_valid/i_ready with payload o_res. With action 0 the count is walked
// down one whole year per cycle and then one month per cycle; with action 1
// whole years and then months are added, one per cycle. The single shared
// accumulator of the datapath sets the pace.
// The walks cover up to YEAR_SPAN - 1 whole years and up to 11 months; a
// date with a year outside the window goes from setup straight to the
// result step. One request is in work at a time; o_ready is high only while
// the sequencer is idle.
// The result sits in an output register; a stalled receiver holds the
// sequencer at its last step until the register is free, after which o_ready
// returns. Reset returns the sequencer to idle and empties the output
// register; no other state is kept between requests.
// ----------------------------------------------------------------------------
module calendar_day_count_converter_top #(
    parameter int unsigned YEAR_SPAN = cdcc_pkg::YEAR_SPAN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cdcc_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output cdcc_pkg::t_res   o_res
);

    cdcc_pkg::t_uctl  w_uctl;
    cdcc_pkg::t_flags w_flags;
    cdcc_pkg::t_res   w_res;
    logic             w_idle;
    logic             w_start;
    logic             w_ofree;
    logic             w_emit;

    cdcc_pkg::t_res   r_out;
    logic             r_ovalid;

    // Request acceptance and output register availability.
    assign o_ready = w_idle;
    assign w_start = i_valid && w_idle;
    assign w_ofree = !r_ovalid || i_ready;
    assign w_emit  = (w_uctl.op == cdcc_pkg::OP_EMIT) && w_uctl.en;

    cdcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ofree (w_ofree),
        .i_flags (w_flags),
        .o_uctl  (w_uctl),
        .o_idle  (w_idle)
    );

    cdcc_dp #(
        .YEAR_SPAN (YEAR_SPAN)
    ) u_dp (
        .i_clk   (i_clk),
        .i_load  (w_start),
        .i_req   (i_req),
        .i_uctl  (w_uctl),
        .o_flags (w_flags),
        .o_res   (w_res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_out;

    // A request in work blocks further requests.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in work");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_ovalid || i_ready))
        else $error("pending result overwritten");

    // A converted date lies inside the year window with a proper month.
    a_date_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.month_out != 4'd0)) |->
        ((o_res.year_out >= 12'(cdcc_pkg::EPOCH_YEAR))
        && (o_res.year_out <= 12'(cdcc_pkg::EPOCH_YEAR + YEAR_SPAN - 1))
        && (o_res.month_out <= cdcc_pkg::MONTHS) && (o_res.day_out != 5'd0)))
        else $error("converted date outside window");

    // The weekday is always a day of the week.
    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.weekday <= 3'd6))
        else $error("weekday out of range");

endmodule

[verif/calendar_day_count_converter_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_count_converter_top_test: self-checking bench for the converter
// Sends day counts and calendar dates through the request channel and checks
// every result against a behavioural calendar computed in the bench. The run
// covers the window edges, leap and century rules, out-of-range fields and
// saturation, then random traffic under varied idle and stall patterns,
// including one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module calendar_day_count_converter_top_test;

    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned CYCLE_LIMIT  = 1500000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned LAST_YEAR    = cdcc_pkg::EPOCH_YEAR + cdcc_pkg::YEAR_SPAN_DEF - 1;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } t_phase;

    logic           i_clk;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    cdcc_pkg::t_req i_req   = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    cdcc_pkg::t_res o_res;

    t_phase         phase = PH_FREE;
    cdcc_pkg::t_req request_queue[$];
    cdcc_pkg::t_res result_queue[$];
    int unsigned    fail_count  = 0;
    int unsigned    cycle_count = 0;
    int unsigned    hold_count  = 0;
    logic           recv_hold;
    logic [6:0]     send_idle_pct;
    logic [6:0]     recv_idle_pct;

    calendar_day_count_converter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gregorian leap rule in full, independent of the window offset.
    function automatic int unsigned days_in_year(input int unsigned yr);
        if ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0))) begin
            return 366;
        end
        return 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input int unsigned mon);
        case (mon)
            2: begin
                return (days_in_year(yr) == 366) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    // Expected result of one request.
    function automatic cdcc_pkg::t_res convert_request(input cdcc_pkg::t_req req);
        cdcc_pkg::t_res res;
        int unsigned    span_days;
        int unsigned    count;
        int unsigned    rem;
        int unsigned    yr;
        int unsigned    mon;
        int unsigned    acc;
        logic           err;
        res       = '0;
        err       = 1'b0;
        count     = 0;
        span_days = 0;
        for (int unsigned y = cdcc_pkg::EPOCH_YEAR; y <= LAST_YEAR; y++) begin
            span_days += days_in_year(y);
        end
        if (req.action == 1'b0) begin
            // Day count to date: walk whole years, then months.
            count = req.day_count_in;
            if (count > span_days - 1) begin
                count = span_days - 1;
                err   = 1'b1;
            end
            rem = count;
            yr  = cdcc_pkg::EPOCH_YEAR;
            while (rem >= days_in_year(yr)) begin
                rem -= days_in_year(yr);
                yr++;
            end
            mon = 1;
            while ((mon < 12) && (rem >= days_in_month(yr, mon))) begin
                rem -= days_in_month(yr, mon);
                mon++;
            end
            res.year_out  = yr[11:0];
            res.month_out = mon[3:0];
            res.day_out   = 5'(rem + 1);
        end else begin
            // Date to day count, with month repair and saturation.
            yr  = req.year_in;
            mon = req.month_in;
            if (mon < 1) begin
                mon = 1;
                err = 1'b1;
            end
            if (mon > 12) begin
                mon = 12;
                err = 1'b1;
            end
            if (yr < cdcc_pkg::EPOCH_YEAR) begin
                count = 0;
                err   = 1'b1;
            end else if (yr > LAST_YEAR) begin
                count = cdcc_pkg::COUNT_MAX;
                err   = 1'b1;
            end else begin
                acc = 0;
                for (int unsigned y = cdcc_pkg::EPOCH_YEAR; y < yr; y++) begin
                    acc += days_in_year(y);
                end
                for (int unsigned m = 1; m < mon; m++) begin
                    acc += days_in_month(yr, m);
                end
                acc += req.day_in;
                if (acc == 0) begin
                    err = 1'b1;
                end else begin
                    acc -= 1;
                end
                if (acc > cdcc_pkg::COUNT_MAX) begin
                    acc = cdcc_pkg::COUNT_MAX;
                    err = 1'b1;
                end
                count = acc;
            end
        end
        res.weekday       = 3'((count + 6) % 7);
        res.day_count_out = count[15:0];
        res.range_error   = err;
        return res;
    endfunction

    function automatic cdcc_pkg::t_req count_request(input int unsigned cnt);
        cdcc_pkg::t_req req;
        req              = '0;
        req.day_count_in = cnt[15:0];
        return req;
    endfunction

    function automatic cdcc_pkg::t_req date_request(input int unsigned yr,
                                                    input int unsigned mon,
                                                    input int unsigned day);
        cdcc_pkg::t_req req;
        req          = '0;
        req.action   = 1'b1;
        req.year_in  = yr[11:0];
        req.month_in = mon[3:0];
        req.day_in   = day[4:0];
        return req;
    endfunction

    // Random request: mostly short walks and well-formed dates, some noise.
    function automatic cdcc_pkg::t_req random_request();
        cdcc_pkg::t_req req;
        int unsigned    pick;
        int unsigned    yr;
        int unsigned    mon;
        req.action       = 1'($urandom);
        req.day_count_in = 16'($urandom);
        req.year_in      = 12'($urandom);
        req.month_in     = 4'($urandom);
        req.day_in       = 5'($urandom);
        pick             = $urandom_range(0, 99);
        if (req.action == 1'b0) begin
            if (pick < 60) begin
                req.day_count_in = 16'($urandom_range(0, 3000));
            end else if (pick < 90) begin
                req.day_count_in = 16'($urandom_range(60000, 65535));
            end
        end else if (pick < 85) begin
            yr  = (pick < 60)
                ? $urandom_range(cdcc_pkg::EPOCH_YEAR, cdcc_pkg::EPOCH_YEAR + 15)
                : $urandom_range(cdcc_pkg::EPOCH_YEAR, LAST_YEAR);
            mon = $urandom_range(1, 12);
            req.year_in  = yr[11:0];
            req.month_in = mon[3:0];
            req.day_in   = 5'($urandom_range(1, days_in_month(yr, mon)));
            if (pick >= 75) begin
                req.day_in = 5'($urandom);
            end
        end else if (pick < 92) begin
            req.year_in = 12'($urandom_range(cdcc_pkg::EPOCH_YEAR - 20, LAST_YEAR + 20));
        end
        return req;
    endfunction

    // Compare one result with the oldest expectation.
    task automatic check_result(input cdcc_pkg::t_res got);
        cdcc_pkg::t_res want;
        logic           bad;
        if (result_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("ERROR: unexpected result y=%0d m=%0d d=%0d wd=%0d cnt=%0d err=%0d",
                         got.year_out, got.month_out, got.day_out, got.weekday,
                         got.day_count_out, got.range_error);
            end
        end else begin
            want = result_queue.pop_front();
            bad  = (got.year_out !== want.year_out) || (got.month_out !== want.month_out)
                || (got.day_out !== want.day_out) || (got.weekday !== want.weekday)
                || (got.day_count_out !== want.day_count_out)
                || (got.range_error !== want.range_error);
            if (bad) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("ERROR: expected y=%0d m=%0d d=%0d wd=%0d cnt=%0d err=%0d",
                             want.year_out, want.month_out, want.day_out, want.weekday,
                             want.day_count_out, want.range_error);
                    $display("       actual   y=%0d m=%0d d=%0d wd=%0d cnt=%0d err=%0d",
                             got.year_out, got.month_out, got.day_out, got.weekday,
                             got.day_count_out, got.range_error);
                end
            end
        end
    endtask

    assign send_idle_pct = (phase == PH_SEND_IDLE) ? 7'd63 :
                           (phase == PH_BOTH_IDLE) ? 7'd31 : 7'd0;
    assign recv_idle_pct = (phase == PH_RECV_STALL) ? 7'd63 :
                           (phase == PH_BOTH_IDLE)  ? 7'd31 : 7'd0;
    assign recv_hold     = (phase == PH_RECV_STALL) && (hold_count < HOLD_CYCLES);

    // Long receiver hold-off at the start of the stall phase.
    always @(posedge i_clk) begin
        if (i_rst_n && recv_hold) begin
            hold_count <= hold_count + 1;
        end
    end

    // Request driver: records the expectation on acceptance, then offers the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                result_queue.push_back(convert_request(i_req));
            end
            if (!i_valid || o_ready) begin
                if ((request_queue.size() != 0)
                    && ($urandom_range(0, 99) >= send_idle_pct)) begin
                    i_req   <= request_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_result(o_res);
            end
            i_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL calendar_day_count_converter_top");
            $finish;
        end
    end

    // Load one idling phase of random requests and wait until they are taken.
    task automatic run_phase(input t_phase ph, input int unsigned n_items);
        phase = ph;
        repeat (n_items) begin
            request_queue.push_back(random_request());
        end
        while (request_queue.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Stimulus sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests: window edges, leap rules, bad fields, saturation.
        request_queue.push_back(count_request(0));
        request_queue.push_back(count_request(1));
        request_queue.push_back(count_request(59));
        request_queue.push_back(count_request(60));
        request_queue.push_back(count_request(365));
        request_queue.push_back(count_request(366));
        request_queue.push_back(count_request(36583));
        request_queue.push_back(count_request(36584));
        request_queue.push_back(count_request(65535));
        request_queue.push_back(date_request(2000, 1, 1));
        request_queue.push_back(date_request(2000, 1, 0));
        request_queue.push_back(date_request(1999, 12, 31));
        request_queue.push_back(date_request(0, 0, 0));
        request_queue.push_back(date_request(2000, 2, 29));
        request_queue.push_back(date_request(2000, 2, 30));
        request_queue.push_back(date_request(2100, 2, 29));
        request_queue.push_back(date_request(2100, 3, 1));
        request_queue.push_back(date_request(2179, 1, 1));
        request_queue.push_back(date_request(2179, 12, 31));
        request_queue.push_back(date_request(2180, 1, 1));
        request_queue.push_back(date_request(4095, 15, 31));
        request_queue.push_back(date_request(2024, 0, 15));
        request_queue.push_back(date_request(2024, 13, 1));
        request_queue.push_back(date_request(2024, 3, 0));
        run_phase(PH_FREE, 0);

        // Random traffic under each idling pattern.
        run_phase(PH_FREE, 260);
        run_phase(PH_SEND_IDLE, 260);
        run_phase(PH_RECV_STALL, 260);
        run_phase(PH_BOTH_IDLE, 250);

        // Drain and let the block settle.
        while (i_valid || (result_queue.size() != 0)) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS calendar_day_count_converter_top");
        end else begin
            $display("FAIL calendar_day_count_converter_top");
        end
        $finish;
    end

endmodule
